// ----- hw/rtl/split_screen_layout_animator_core_defines.svh -----
// ----------------------------------------------------------------------------
// Split-screen layout animator: assertion macros
// Shared shorthand for the concurrent checks on clock and reset.
// ----------------------------------------------------------------------------
`ifndef SPLIT_SCREEN_LAYOUT_ANIMATOR_CORE_DEFINES_SVH
`define SPLIT_SCREEN_LAYOUT_ANIMATOR_CORE_DEFINES_SVH

// same-cycle implication
`define SSLA_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SSLA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/ssla_pkg.sv -----
// ----------------------------------------------------------------------------
// Split-screen layout animator: package
// Payload structs, unit interfaces, register indexes and shared constants.
// ----------------------------------------------------------------------------
package ssla_pkg;

   localparam int DIM_W  = 12;
   localparam int MS_W   = 16;
   localparam int PROG_W = 10;

   localparam logic [PROG_W-1:0] PROG_ONE  = 10'd1000;
   localparam logic [DIM_W-1:0]  EVEN_MASK = 12'hFFE;

   // shared multiplier
   localparam int MUL_A_W = 20;
   localparam int MUL_B_W = 12;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;

   // shared divider
   localparam int DIV_W        = 32;
   localparam int DEN_W        = 16;
   localparam int DIV_RADIX_W  = 2;
   localparam int DIV_CYCLES   = DIV_W / DIV_RADIX_W;
   localparam int DIV_CNT_W    = $clog2(DIV_CYCLES);

   // register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_SURFACE_W = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SURFACE_H = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STREAM_W  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_STREAM_H  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DURATION  = 3'd4;

   localparam logic [DIM_W-1:0] RST_SURFACE_W = 12'd800;
   localparam logic [DIM_W-1:0] RST_SURFACE_H = 12'd480;
   localparam logic [DIM_W-1:0] RST_STREAM_W  = 12'd800;
   localparam logic [DIM_W-1:0] RST_STREAM_H  = 12'd480;
   localparam logic [MS_W-1:0]  RST_DURATION  = 16'd500;

   typedef logic [PROD_W-1:0] prod_type;

   typedef struct packed {
      logic [MS_W-1:0]  tick_ms;
      logic             toggle_request;
      logic [DIM_W-1:0] touch_x;
      logic [DIM_W-1:0] touch_y;
   } req_payload_type;

   typedef struct packed {
      logic             stepped;
      logic             still_moving;
      logic             gui_visible;
      logic [DIM_W-1:0] area_w;
      logic [DIM_W-1:0] area_h;
      logic [DIM_W-1:0] video_x;
      logic [DIM_W-1:0] video_y;
      logic [DIM_W-1:0] video_w;
      logic [DIM_W-1:0] video_h;
      logic             touch_hit;
      logic [DIM_W-1:0] touch_vx;
      logic [DIM_W-1:0] touch_vy;
   } rsp_payload_type;

   typedef struct packed {
      logic [DIM_W-1:0] surface_width;
      logic [DIM_W-1:0] surface_height;
      logic [DIM_W-1:0] stream_width;
      logic [DIM_W-1:0] stream_height;
      logic [MS_W-1:0]  anim_duration_ms;
   } cfg_type;

   typedef struct packed {
      logic [MUL_A_W-1:0] a;
      logic [MUL_B_W-1:0] b;
   } mul_req_type;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] num;
      logic [DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quo;
   } div_rsp_type;

endpackage

// ----- hw/rtl/ssla_mul.sv -----
// ----------------------------------------------------------------------------
// Split-screen layout animator: shared multiplier
// One unsigned 20x12 multiply per cycle, product registered.
// ----------------------------------------------------------------------------
module ssla_mul (
   input  logic                 clock,
   input  ssla_pkg::mul_req_type mul_req,
   output ssla_pkg::prod_type    mul_prod
);
   import ssla_pkg::*;

   prod_type prod_ff;
   prod_type prod_in;

   assign prod_in  = PROD_W'(mul_req.a) * PROD_W'(mul_req.b);
   assign mul_prod = prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

// ----- hw/rtl/ssla_div.sv -----
// ----------------------------------------------------------------------------
// Split-screen layout animator: shared divider
// Restoring unsigned divider, 32/16 bits, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module ssla_div (
   input  logic                  clock,
   input  logic                  reset,
   input  ssla_pkg::div_req_type div_req,
   output ssla_pkg::div_rsp_type div_rsp
);
   import ssla_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DEN_W-1:0]     den_ff, den_in;
   logic [DEN_W-1:0]     rem_ff, rem_in;
   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [DEN_W-1:0]     rem_step;
   logic [DIV_W-1:0]     quo_step;

   always_comb begin
      logic [DEN_W:0] trial;
      logic           qbit;
      rem_step = rem_ff;
      quo_step = quo_ff;
      for (int i = 0; i < DIV_RADIX_W; i++) begin
         trial = {rem_step, quo_step[DIV_W-1]};
         qbit  = (trial >= {1'b0, den_ff});
         if (qbit) begin
            trial = trial - {1'b0, den_ff};
         end
         rem_step = trial[DEN_W-1:0];
         quo_step = {quo_step[DIV_W-2:0], qbit};
      end
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         den_in  = div_req.den;
         rem_in  = '0;
         quo_in  = div_req.num;
      end else if (busy_ff) begin
         rem_in = rem_step;
         quo_in = quo_step;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_CYCLES - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quo  = quo_ff;

endmodule

// ----- hw/rtl/ssla_seq.sv -----
// ----------------------------------------------------------------------------
// Split-screen layout animator: sequencer
// Holds the animation state and steps one tick through the shared units.
// ----------------------------------------------------------------------------
module ssla_seq (
   input  logic                      clock,
   input  logic                      reset,
   input  ssla_pkg::cfg_type         cfg,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  ssla_pkg::req_payload_type in_data,
   output logic                      res_valid,
   input  logic                      res_take,
   output ssla_pkg::rsp_payload_type res_data,
   output ssla_pkg::mul_req_type     mul_req,
   input  ssla_pkg::prod_type        mul_prod,
   output ssla_pkg::div_req_type     div_req,
   input  ssla_pkg::div_rsp_type     div_rsp
);
   import ssla_pkg::*;

   localparam int ST_W = 5;
   localparam logic [ST_W-1:0] ST_IDLE    = 5'd0;
   localparam logic [ST_W-1:0] ST_BY_MUL  = 5'd1;
   localparam logic [ST_W-1:0] ST_BY_DIV  = 5'd2;
   localparam logic [ST_W-1:0] ST_BY_WAIT = 5'd3;
   localparam logic [ST_W-1:0] ST_SQ_MUL  = 5'd4;
   localparam logic [ST_W-1:0] ST_CU_MUL  = 5'd5;
   localparam logic [ST_W-1:0] ST_CU_DIV  = 5'd6;
   localparam logic [ST_W-1:0] ST_CU_WAIT = 5'd7;
   localparam logic [ST_W-1:0] ST_E_DIV   = 5'd8;
   localparam logic [ST_W-1:0] ST_E_WAIT  = 5'd9;
   localparam logic [ST_W-1:0] ST_W_MUL   = 5'd10;
   localparam logic [ST_W-1:0] ST_W_DIV   = 5'd11;
   localparam logic [ST_W-1:0] ST_W_WAIT  = 5'd12;
   localparam logic [ST_W-1:0] ST_H_MUL   = 5'd13;
   localparam logic [ST_W-1:0] ST_H_DIV   = 5'd14;
   localparam logic [ST_W-1:0] ST_H_WAIT  = 5'd15;
   localparam logic [ST_W-1:0] ST_FIT     = 5'd16;
   localparam logic [ST_W-1:0] ST_PLACE   = 5'd17;
   localparam logic [ST_W-1:0] ST_HIT     = 5'd18;
   localparam logic [ST_W-1:0] ST_X_MUL   = 5'd19;
   localparam logic [ST_W-1:0] ST_X_DIV   = 5'd20;
   localparam logic [ST_W-1:0] ST_X_WAIT  = 5'd21;
   localparam logic [ST_W-1:0] ST_Y_MUL   = 5'd22;
   localparam logic [ST_W-1:0] ST_Y_DIV   = 5'd23;
   localparam logic [ST_W-1:0] ST_Y_WAIT  = 5'd24;
   localparam logic [ST_W-1:0] ST_DONE    = 5'd25;

   localparam int A3_W = 22;

   logic [ST_W-1:0]   state_ff, state_in;
   logic              target_ff, target_in;
   logic [PROG_W-1:0] prog_ff, prog_in;
   logic [MS_W-1:0]   elapsed_ff, elapsed_in;
   logic [DIM_W-1:0]  tx_ff, tx_in;
   logic [DIM_W-1:0]  ty_ff, ty_in;
   logic              stepped_ff, stepped_in;
   logic              moving_ff, moving_in;
   logic [A3_W-1:0]   a3_ff, a3_in;
   logic [A3_W-1:0]   t_ff, t_in;
   logic [PROG_W-1:0] e_ff, e_in;
   logic [DIM_W-1:0]  aw_ff, aw_in;
   logic [DIM_W-1:0]  ah_ff, ah_in;
   logic [DIM_W-1:0]  vw_ff, vw_in;
   logic [DIM_W-1:0]  vh_ff, vh_in;
   logic [DIM_W-1:0]  vx_ff, vx_in;
   logic [DIM_W-1:0]  vy_ff, vy_in;
   logic              hit_ff, hit_in;
   logic [DIM_W-1:0]  mx_ff, mx_in;
   logic [DIM_W-1:0]  my_ff, my_in;

   always_comb begin
      logic [PROG_W-1:0] want;
      logic [PROG_W-1:0] gap;
      logic [PROG_W-1:0] next_prog;
      logic [DIV_W-1:0]  by;
      logic [DIM_W-1:0]  span;
      logic              hit;

      state_in   = state_ff;
      target_in  = target_ff;
      prog_in    = prog_ff;
      elapsed_in = elapsed_ff;
      tx_in      = tx_ff;
      ty_in      = ty_ff;
      stepped_in = stepped_ff;
      moving_in  = moving_ff;
      a3_in      = a3_ff;
      t_in       = t_ff;
      e_in       = e_ff;
      aw_in      = aw_ff;
      ah_in      = ah_ff;
      vw_in      = vw_ff;
      vh_in      = vh_ff;
      vx_in      = vx_ff;
      vy_in      = vy_ff;
      hit_in     = hit_ff;
      mx_in      = mx_ff;
      my_in      = my_ff;

      mul_req       = '0;
      div_req       = '0;
      div_req.den   = DEN_W'(PROG_ONE);
      res_valid     = 1'b0;

      want      = target_ff ? PROG_ONE : '0;
      gap       = PROG_ONE - prog_ff;
      by        = (div_rsp.quo == '0) ? DIV_W'(1) : div_rsp.quo;
      next_prog = prog_ff;
      span      = '0;
      hit       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               target_in  = target_ff ^ in_data.toggle_request;
               stepped_in = (prog_ff != (target_in ? PROG_ONE : '0));
               elapsed_in = in_data.tick_ms;
               tx_in      = in_data.touch_x;
               ty_in      = in_data.touch_y;
               state_in   = ST_BY_MUL;
            end
         end
         ST_BY_MUL: begin
            mul_req.a = MUL_A_W'(elapsed_ff);
            mul_req.b = MUL_B_W'(PROG_ONE);
            state_in  = ST_BY_DIV;
         end
         ST_BY_DIV: begin
            div_req.start = 1'b1;
            div_req.num   = DIV_W'(mul_prod);
            div_req.den   = (cfg.anim_duration_ms == '0) ? DEN_W'(1) : cfg.anim_duration_ms;
            state_in      = ST_BY_WAIT;
         end
         ST_BY_WAIT: begin
            if (div_rsp.done) begin
               if (stepped_ff) begin
                  if (target_ff) begin
                     if (by >= DIV_W'(gap)) begin
                        next_prog = PROG_ONE;
                     end else begin
                        next_prog = prog_ff + by[PROG_W-1:0];
                     end
                  end else begin
                     if (by > DIV_W'(prog_ff)) begin
                        next_prog = '0;
                     end else begin
                        next_prog = prog_ff - by[PROG_W-1:0];
                     end
                  end
               end
               prog_in   = next_prog;
               moving_in = (next_prog != want);
               state_in  = ST_SQ_MUL;
            end
         end
         ST_SQ_MUL: begin
            mul_req.a = MUL_A_W'(prog_ff);
            mul_req.b = MUL_B_W'(prog_ff);
            state_in  = ST_CU_MUL;
         end
         ST_CU_MUL: begin
            // p^2 is back; start p^3 and keep 3p^2
            mul_req.a = mul_prod[MUL_A_W-1:0];
            mul_req.b = MUL_B_W'(prog_ff);
            a3_in     = {mul_prod[A3_W-2:0], 1'b0} + A3_W'(mul_prod[MUL_A_W-1:0]);
            state_in  = ST_CU_DIV;
         end
         ST_CU_DIV: begin
            div_req.start = 1'b1;
            div_req.num   = {mul_prod[DIV_W-2:0], 1'b0};
            state_in      = ST_CU_WAIT;
         end
         ST_CU_WAIT: begin
            if (div_rsp.done) begin
               t_in     = a3_ff - div_rsp.quo[A3_W-1:0];
               state_in = ST_E_DIV;
            end
         end
         ST_E_DIV: begin
            div_req.start = 1'b1;
            div_req.num   = DIV_W'(t_ff);
            state_in      = ST_E_WAIT;
         end
         ST_E_WAIT: begin
            if (div_rsp.done) begin
               e_in     = div_rsp.quo[PROG_W-1:0];
               state_in = ST_W_MUL;
            end
         end
         ST_W_MUL: begin
            mul_req.a = MUL_A_W'(e_ff);
            mul_req.b = MUL_B_W'(cfg.surface_width >> 1);
            state_in  = ST_W_DIV;
         end
         ST_W_DIV: begin
            div_req.start = 1'b1;
            div_req.num   = DIV_W'(mul_prod);
            state_in      = ST_W_WAIT;
         end
         ST_W_WAIT: begin
            if (div_rsp.done) begin
               aw_in    = (cfg.surface_width - div_rsp.quo[DIM_W-1:0]) & EVEN_MASK;
               state_in = ST_H_MUL;
            end
         end
         ST_H_MUL: begin
            mul_req.a = MUL_A_W'(e_ff);
            mul_req.b = MUL_B_W'(cfg.surface_height >> 1);
            state_in  = ST_H_DIV;
         end
         ST_H_DIV: begin
            div_req.start = 1'b1;
            div_req.num   = DIV_W'(mul_prod);
            state_in      = ST_H_WAIT;
         end
         ST_H_WAIT: begin
            if (div_rsp.done) begin
               ah_in    = (cfg.surface_height - div_rsp.quo[DIM_W-1:0]) & EVEN_MASK;
               state_in = ST_FIT;
            end
         end
         ST_FIT: begin
            vw_in    = ((aw_ff < cfg.stream_width) ? aw_ff : cfg.stream_width) & EVEN_MASK;
            vh_in    = ((ah_ff < cfg.stream_height) ? ah_ff : cfg.stream_height) & EVEN_MASK;
            state_in = ST_PLACE;
         end
         ST_PLACE: begin
            span     = aw_ff - vw_ff;
            vx_in    = {1'b0, span[DIM_W-1:1]} & EVEN_MASK;
            span     = ah_ff - vh_ff;
            vy_in    = {1'b0, span[DIM_W-1:1]};
            state_in = ST_HIT;
         end
         ST_HIT: begin
            hit = (tx_ff >= vx_ff) && (ty_ff >= vy_ff)
               && ({1'b0, tx_ff} < ({1'b0, vx_ff} + {1'b0, vw_ff}))
               && ({1'b0, ty_ff} < ({1'b0, vy_ff} + {1'b0, vh_ff}))
               && (vw_ff != '0) && (vh_ff != '0);
            hit_in   = hit;
            mx_in    = '0;
            my_in    = '0;
            state_in = hit ? ST_X_MUL : ST_DONE;
         end
         ST_X_MUL: begin
            mul_req.a = MUL_A_W'(tx_ff - vx_ff);
            mul_req.b = cfg.stream_width;
            state_in  = ST_X_DIV;
         end
         ST_X_DIV: begin
            div_req.start = 1'b1;
            div_req.num   = DIV_W'(mul_prod);
            div_req.den   = DEN_W'(vw_ff);
            state_in      = ST_X_WAIT;
         end
         ST_X_WAIT: begin
            if (div_rsp.done) begin
               mx_in    = div_rsp.quo[DIM_W-1:0];
               state_in = ST_Y_MUL;
            end
         end
         ST_Y_MUL: begin
            mul_req.a = MUL_A_W'(ty_ff - vy_ff);
            mul_req.b = cfg.stream_height;
            state_in  = ST_Y_DIV;
         end
         ST_Y_DIV: begin
            div_req.start = 1'b1;
            div_req.num   = DIV_W'(mul_prod);
            div_req.den   = DEN_W'(vh_ff);
            state_in      = ST_Y_WAIT;
         end
         ST_Y_WAIT: begin
            if (div_rsp.done) begin
               my_in    = div_rsp.quo[DIM_W-1:0];
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            res_valid = 1'b1;
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         target_ff <= 1'b0;
         prog_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         target_ff <= target_in;
         prog_ff   <= prog_in;
      end
      elapsed_ff <= elapsed_in;
      tx_ff      <= tx_in;
      ty_ff      <= ty_in;
      stepped_ff <= stepped_in;
      moving_ff  <= moving_in;
      a3_ff      <= a3_in;
      t_ff       <= t_in;
      e_ff       <= e_in;
      aw_ff      <= aw_in;
      ah_ff      <= ah_in;
      vw_ff      <= vw_in;
      vh_ff      <= vh_in;
      vx_ff      <= vx_in;
      vy_ff      <= vy_in;
      hit_ff     <= hit_in;
      mx_ff      <= mx_in;
      my_ff      <= my_in;
   end

   assign in_ready = (state_ff == ST_IDLE);

   assign res_data.stepped      = stepped_ff;
   assign res_data.still_moving = moving_ff;
   assign res_data.gui_visible  = (aw_ff < cfg.surface_width);
   assign res_data.area_w       = aw_ff;
   assign res_data.area_h       = ah_ff;
   assign res_data.video_x      = vx_ff;
   assign res_data.video_y      = vy_ff;
   assign res_data.video_w      = vw_ff;
   assign res_data.video_h      = vh_ff;
   assign res_data.touch_hit    = hit_ff;
   assign res_data.touch_vx     = mx_ff;
   assign res_data.touch_vy     = my_ff;

endmodule

// ----- hw/rtl/split_screen_layout_animator_core.sv -----
// ----------------------------------------------------------------------------
// Split-screen layout animator core
// Eased full/split screen transition, video placement and touch mapping.
// ----------------------------------------------------------------------------
// Each tick word may flip the target mode, then moves the progress toward
// it and returns one word with the video area, the centred picture and the
// touch point in stream coordinates. The work is done by one shared divider
// retiring two quotient bits a cycle, five divisions per tick and two more
// on a hit, and one shared registered multiplier. req_ready is low while a
// tick is in work; a finished word waits in the output register while the
// next tick is taken. Registers are written through csr_ while the core is
// idle; the user must keep to this, as the core does not enforce it.
// csr_ready is always high and indexes past the list are ignored.
// ----------------------------------------------------------------------------
module split_screen_layout_animator_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  ssla_pkg::req_payload_type        req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output ssla_pkg::rsp_payload_type        rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [ssla_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ssla_pkg::MS_W-1:0]        csr_wdata
);
   import ssla_pkg::*;

   cfg_type         cfg_ff, cfg_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   logic            res_valid;
   logic            res_take;
   rsp_payload_type res_data;
   mul_req_type     mul_req;
   prod_type        mul_prod;
   div_req_type     div_req;
   div_rsp_type     div_rsp;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_SURFACE_W: cfg_in.surface_width    = csr_wdata[DIM_W-1:0];
            CSR_SURFACE_H: cfg_in.surface_height   = csr_wdata[DIM_W-1:0];
            CSR_STREAM_W:  cfg_in.stream_width     = csr_wdata[DIM_W-1:0];
            CSR_STREAM_H:  cfg_in.stream_height    = csr_wdata[DIM_W-1:0];
            CSR_DURATION:  cfg_in.anim_duration_ms = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // output register frees the sequencer once the word is parked
   assign res_take = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_valid && res_take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_data;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.surface_width    <= RST_SURFACE_W;
         cfg_ff.surface_height   <= RST_SURFACE_H;
         cfg_ff.stream_width     <= RST_STREAM_W;
         cfg_ff.stream_height    <= RST_STREAM_H;
         cfg_ff.anim_duration_ms <= RST_DURATION;
         rsp_valid_ff            <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   ssla_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .res_valid (res_valid),
      .res_take  (res_take),
      .res_data  (res_data),
      .mul_req   (mul_req),
      .mul_prod  (mul_prod),
      .div_req   (div_req),
      .div_rsp   (div_rsp)
   );

   ssla_mul u_mul (
      .clock    (clock),
      .mul_req  (mul_req),
      .mul_prod (mul_prod)
   );

   ssla_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

endmodule

// ----- hw/rtl/ssla_checker.sv -----
// ----------------------------------------------------------------------------
// Split-screen layout animator: port checker
// Concurrent checks on the core's ports, bound to the top level.
// ----------------------------------------------------------------------------
`include "split_screen_layout_animator_core_defines.svh"

module ssla_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input ssla_pkg::rsp_payload_type rsp_data
);
   import ssla_pkg::*;

   // stalled word holds
   `SSLA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "rsp word changed while stalled")

   // one tick in work at a time
   `SSLA_ASSERT_NEXT(a_busy_after_take, req_valid && req_ready, !req_ready, "req taken while a tick is in work")

   // a miss reports zero coordinates
   `SSLA_ASSERT_NOW(a_miss_zero, rsp_valid && !rsp_data.touch_hit, (rsp_data.touch_vx == '0) && (rsp_data.touch_vy == '0), "touch coordinates set on a miss")

   // progress cannot still move unless it moved this tick, and area_w, video_w and video_x stay even
   `SSLA_ASSERT_NOW(a_moving_stepped, rsp_valid && rsp_data.still_moving, rsp_data.stepped && !rsp_data.area_w[0] && !rsp_data.video_w[0] && !rsp_data.video_x[0], "moving word not stepped or geometry odd")

endmodule

bind split_screen_layout_animator_core ssla_checker u_ssla_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
